>>> sv/mtt_pkg.sv
`default_nettype none

package mtt_pkg;

   // Depth of the result queue behind the scanner; at least two.
   localparam int unsigned FIFO_DEPTH = 4;

   // Token kinds as they appear on the result channel.
   localparam logic [2:0] KIND_TEXT  = 3'd0;
   localparam logic [2:0] KIND_OPEN  = 3'd1;
   localparam logic [2:0] KIND_CLOSE = 3'd2;
   localparam logic [2:0] KIND_SLASH = 3'd3;
   localparam logic [2:0] KIND_TNAME = 3'd4;
   localparam logic [2:0] KIND_ANAME = 3'd5;
   localparam logic [2:0] KIND_EQ    = 3'd6;
   localparam logic [2:0] KIND_VALUE = 3'd7;

   // Characters the scanner reacts to.
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_NUL   = 8'h00;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_TEXT   = 9'b000000010,
      ST_TAG    = 9'b000000100,
      ST_TNAME  = 9'b000001000,
      ST_TSPACE = 9'b000010000,
      ST_ASTART = 9'b000100000,
      ST_ANAME  = 9'b001000000,
      ST_VSTART = 9'b010000000,
      ST_VALUE  = 9'b100000000
   } state_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] tbyte;
      logic       present;
      logic       tend;
      logic       last;
   } tok_type;

   typedef struct packed {
      logic [1:0] count;
      tok_type    first;
      tok_type    second;
      state_type  next_state;
   } scan_out_type;

endpackage

`default_nettype wire

>>> sv/mtt_scan.sv
`default_nettype none

// Decides, for one character and the current scanner state, the zero to two
// result items and the next state.
module mtt_scan (
   input  wire mtt_pkg::state_type    state,
   input  wire logic [7:0]            char_in,
   input  wire logic                  eot,
   output mtt_pkg::scan_out_type      scan_out
);

   function automatic logic is_name(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || (c == mtt_pkg::CH_DASH);
   endfunction

   function automatic mtt_pkg::tok_type tok_byte(input logic [2:0] kind,
                                                 input logic [7:0] c,
                                                 input logic       tend);
      mtt_pkg::tok_type t;
      t.kind    = kind;
      t.tbyte   = c;
      t.present = 1'b1;
      t.tend    = tend;
      t.last    = 1'b0;
      return t;
   endfunction

   function automatic mtt_pkg::tok_type tok_close(input logic [2:0] kind);
      mtt_pkg::tok_type t;
      t.kind    = kind;
      t.tbyte   = 8'h00;
      t.present = 1'b0;
      t.tend    = 1'b1;
      t.last    = 1'b0;
      return t;
   endfunction

   // What the attribute-start state does with this character, used by every
   // state that falls through into it.
   logic                 as_emit;
   mtt_pkg::tok_type     as_tok;
   mtt_pkg::state_type   as_next;
   logic                 stop;

   always_comb begin
      as_emit = 1'b0;
      as_tok  = tok_close(mtt_pkg::KIND_ANAME);
      as_next = mtt_pkg::ST_ASTART;
      if (char_in == mtt_pkg::CH_SPACE) begin
         as_next = mtt_pkg::ST_ASTART;
      end else if (is_name(char_in)) begin
         as_emit = 1'b1;
         as_tok  = tok_byte(mtt_pkg::KIND_ANAME, char_in, 1'b0);
         as_next = mtt_pkg::ST_ANAME;
      end else if (char_in == mtt_pkg::CH_EQ) begin
         as_emit = 1'b1;
         as_tok  = tok_byte(mtt_pkg::KIND_EQ, char_in, 1'b1);
         as_next = mtt_pkg::ST_VSTART;
      end else if (char_in == mtt_pkg::CH_SLASH) begin
         as_emit = 1'b1;
         as_tok  = tok_byte(mtt_pkg::KIND_SLASH, char_in, 1'b1);
         as_next = mtt_pkg::ST_TAG;
      end else if (char_in == mtt_pkg::CH_GT) begin
         as_emit = 1'b1;
         as_tok  = tok_byte(mtt_pkg::KIND_CLOSE, char_in, 1'b1);
         as_next = mtt_pkg::ST_IDLE;
      end
      // Any other character is dropped here.
   end

   assign stop = eot || (char_in == mtt_pkg::CH_NUL);

   always_comb begin
      scan_out            = '0;
      scan_out.next_state = state;
      if (stop) begin
         scan_out.next_state = mtt_pkg::ST_IDLE;
         unique case (state)
            mtt_pkg::ST_TEXT: begin
               scan_out.count = 2'd1;
               scan_out.first = tok_close(mtt_pkg::KIND_TEXT);
            end
            mtt_pkg::ST_TNAME: begin
               scan_out.count = 2'd1;
               scan_out.first = tok_close(mtt_pkg::KIND_TNAME);
            end
            mtt_pkg::ST_ANAME: begin
               scan_out.count = 2'd1;
               scan_out.first = tok_close(mtt_pkg::KIND_ANAME);
            end
            mtt_pkg::ST_VALUE: begin
               scan_out.count = 2'd1;
               scan_out.first = tok_close(mtt_pkg::KIND_VALUE);
            end
            default: begin
               scan_out.count = 2'd0;
            end
         endcase
      end else begin
         unique case (state)
            mtt_pkg::ST_TEXT: begin
               if (char_in == mtt_pkg::CH_LT) begin
                  scan_out.count      = 2'd2;
                  scan_out.first      = tok_close(mtt_pkg::KIND_TEXT);
                  scan_out.second     = tok_byte(mtt_pkg::KIND_OPEN, char_in, 1'b1);
                  scan_out.next_state = mtt_pkg::ST_TAG;
               end else begin
                  scan_out.count = 2'd1;
                  scan_out.first = tok_byte(mtt_pkg::KIND_TEXT, char_in, 1'b0);
               end
            end
            mtt_pkg::ST_TAG: begin
               if (char_in == mtt_pkg::CH_GT) begin
                  scan_out.count      = 2'd1;
                  scan_out.first      = tok_byte(mtt_pkg::KIND_CLOSE, char_in, 1'b1);
                  scan_out.next_state = mtt_pkg::ST_IDLE;
               end else if (char_in == mtt_pkg::CH_SLASH) begin
                  scan_out.count = 2'd1;
                  scan_out.first = tok_byte(mtt_pkg::KIND_SLASH, char_in, 1'b1);
               end else if (char_in == mtt_pkg::CH_SPACE) begin
                  scan_out.next_state = mtt_pkg::ST_TSPACE;
               end else begin
                  scan_out.count      = 2'd1;
                  scan_out.first      = tok_byte(mtt_pkg::KIND_TNAME, char_in, 1'b0);
                  scan_out.next_state = mtt_pkg::ST_TNAME;
               end
            end
            mtt_pkg::ST_TNAME: begin
               if (char_in == mtt_pkg::CH_GT) begin
                  scan_out.count      = 2'd2;
                  scan_out.first      = tok_close(mtt_pkg::KIND_TNAME);
                  scan_out.second     = tok_byte(mtt_pkg::KIND_CLOSE, char_in, 1'b1);
                  scan_out.next_state = mtt_pkg::ST_IDLE;
               end else if (char_in == mtt_pkg::CH_SPACE) begin
                  scan_out.count      = 2'd1;
                  scan_out.first      = tok_close(mtt_pkg::KIND_TNAME);
                  scan_out.next_state = mtt_pkg::ST_TSPACE;
               end else if (char_in == mtt_pkg::CH_SLASH) begin
                  scan_out.count      = 2'd2;
                  scan_out.first      = tok_close(mtt_pkg::KIND_TNAME);
                  scan_out.second     = tok_byte(mtt_pkg::KIND_SLASH, char_in, 1'b1);
                  scan_out.next_state = mtt_pkg::ST_TAG;
               end else begin
                  scan_out.count = 2'd1;
                  scan_out.first = tok_byte(mtt_pkg::KIND_TNAME, char_in, 1'b0);
               end
            end
            mtt_pkg::ST_TSPACE: begin
               if (char_in != mtt_pkg::CH_SPACE) begin
                  scan_out.count      = {1'b0, as_emit};
                  scan_out.first      = as_tok;
                  scan_out.next_state = as_next;
               end
            end
            mtt_pkg::ST_ASTART: begin
               scan_out.count      = {1'b0, as_emit};
               scan_out.first      = as_tok;
               scan_out.next_state = as_next;
            end
            mtt_pkg::ST_ANAME: begin
               if (is_name(char_in)) begin
                  scan_out.count = 2'd1;
                  scan_out.first = tok_byte(mtt_pkg::KIND_ANAME, char_in, 1'b0);
               end else begin
                  // Close the name, then treat the character as at attribute start.
                  scan_out.count      = as_emit ? 2'd2 : 2'd1;
                  scan_out.first      = tok_close(mtt_pkg::KIND_ANAME);
                  scan_out.second     = as_tok;
                  scan_out.next_state = as_next;
               end
            end
            mtt_pkg::ST_VSTART: begin
               if (char_in == mtt_pkg::CH_QUOTE) begin
                  scan_out.next_state = mtt_pkg::ST_VALUE;
               end else if (char_in != mtt_pkg::CH_SPACE) begin
                  scan_out.count      = {1'b0, as_emit};
                  scan_out.first      = as_tok;
                  scan_out.next_state = as_next;
               end
            end
            mtt_pkg::ST_VALUE: begin
               if (char_in == mtt_pkg::CH_QUOTE) begin
                  scan_out.count      = 2'd1;
                  scan_out.first      = tok_close(mtt_pkg::KIND_VALUE);
                  scan_out.next_state = mtt_pkg::ST_ASTART;
               end else begin
                  scan_out.count = 2'd1;
                  scan_out.first = tok_byte(mtt_pkg::KIND_VALUE, char_in, 1'b0);
               end
            end
            default: begin
               // Idle, and any corrupted code behaves the same way.
               if (char_in == mtt_pkg::CH_LT) begin
                  scan_out.count      = 2'd1;
                  scan_out.first      = tok_byte(mtt_pkg::KIND_OPEN, char_in, 1'b1);
                  scan_out.next_state = mtt_pkg::ST_TAG;
               end else begin
                  scan_out.count      = 2'd1;
                  scan_out.first      = tok_byte(mtt_pkg::KIND_TEXT, char_in, 1'b0);
                  scan_out.next_state = mtt_pkg::ST_TEXT;
               end
            end
         endcase
      end
      scan_out.first.last  = (scan_out.count == 2'd1);
      scan_out.second.last = (scan_out.count == 2'd2);
   end

endmodule

`default_nettype wire

>>> sv/mtt_fifo.sv
`default_nettype none

// Small result queue: takes zero, one or two items per cycle, gives one.
module mtt_fifo #(
   parameter int unsigned DEPTH = mtt_pkg::FIFO_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [1:0]       push_count,
   input  wire mtt_pkg::tok_type push_first,
   input  wire mtt_pkg::tok_type push_second,
   output logic                  room_two,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output mtt_pkg::tok_type      out_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   mtt_pkg::tok_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_ptr_next;
   logic               pop;

   assign wr_ptr_next = ptr_inc(wr_ptr_ff);
   assign out_valid   = (count_ff != '0);
   assign out_item    = mem_ff[rd_ptr_ff];
   assign pop         = out_valid && out_ready;
   assign room_two    = (count_ff <= CNT_W'(DEPTH - 2));

   always_comb begin
      count_in  = count_ff + CNT_W'(push_count) - CNT_W'(pop);
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      case (push_count)
         2'd1:    wr_ptr_in = wr_ptr_next;
         2'd2:    wr_ptr_in = ptr_inc(wr_ptr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push_second;
      end
   end

endmodule

`default_nettype wire

>>> sv/markup_tag_tokenizer_unit.sv
// Markup tag tokenizer. Markup text enters one byte per item on the req_
// channel; req_tlast set marks the end of the document instead of a byte
// (a zero byte does the same). Tokens leave on the rsp_ channel: each byte of
// a text, tag name, attribute name or quoted value token comes out tagged
// with its kind, and a byte-less item with token_end set closes the token.
// The characters '<', '>', '/' and '=' in their places give one complete
// item each. rsp_tlast marks the final result item caused by an input item;
// an input item may cause zero, one or two result items.
// An accepted item sits in the input register, is scanned and written into
// the result queue at the next edge on which the queue has room for two
// results; with an empty queue, its first result shows right after that edge.
// Throughput: one input item per cycle while the queue has room for two
// results; the output drains one result per cycle while rsp_tready is high,
// so a long run of two-result items is paced by the output port.
// A stalled receiver fills the queue, which then holds the input register
// and drops req_tready; nothing is lost. Reset empties the queue and the
// input register and returns the scanner to content with no token open.
`default_nettype none

module markup_tag_tokenizer_unit #(
   parameter int unsigned FIFO_DEPTH = mtt_pkg::FIFO_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   input  wire logic        req_tlast,   // end_of_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] token_byte, [8] token_end, rest zero
   output logic [3:0]       rsp_tuser,   // [2:0] token_kind, [3] byte_present
   output logic             rsp_tlast    // last_of_run
);

   // Input register.
   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_eot_ff;

   // Scanner state.
   mtt_pkg::state_type   state_ff, state_in;

   mtt_pkg::scan_out_type scan_out;
   mtt_pkg::tok_type      head;
   logic                  room_two;
   logic                  consume;
   logic [1:0]            push_count;

   // The held item is scanned only when the queue can take both of its
   // possible results.
   assign consume    = in_valid_ff && room_two;
   assign req_tready = !in_valid_ff || consume;
   assign push_count = consume ? scan_out.count : 2'd0;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
      state_in = consume ? scan_out.next_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= mtt_pkg::ST_IDLE;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eot_ff  <= req_tlast;
      end
   end

   mtt_scan u_scan (
      .state    (state_ff),
      .char_in  (in_byte_ff),
      .eot      (in_eot_ff),
      .scan_out (scan_out)
   );

   mtt_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (scan_out.first),
      .push_second (scan_out.second),
      .room_two    (room_two),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_item    (head)
   );

   assign rsp_tdata = {7'd0, head.tend, head.tbyte};
   assign rsp_tuser = {head.present, head.kind};
   assign rsp_tlast = head.last;

endmodule

`default_nettype wire

>>> sv/mtt_checker.sv
`default_nettype none

module mtt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [3:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   logic [2:0] kind;
   assign kind = rsp_tuser[2:0];

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   // An item without a byte only ever closes a token, and carries a zero byte.
   a_bare_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[3] |-> rsp_tdata[8] && (rsp_tdata[7:0] == 8'h00))
      else $error("byte-less item that does not close a token");

   // Single-character tokens are always complete and carry their byte.
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (kind == mtt_pkg::KIND_OPEN || kind == mtt_pkg::KIND_CLOSE ||
                     kind == mtt_pkg::KIND_SLASH || kind == mtt_pkg::KIND_EQ)
         |-> rsp_tuser[3] && rsp_tdata[8])
      else $error("single-character token not complete");

   // Right after reset nothing comes out and the input side is open.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty and ready right after reset");

endmodule

bind markup_tag_tokenizer_unit mtt_checker u_mtt_checker (.*);

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the markup tag tokenizer. An initial block builds a
// list of input items (short hand-written documents first, then random
// documents), a clocked driver plays them onto the req_ channel, and a clocked
// monitor predicts the token items for every accepted input item and checks
// every item that leaves on the rsp_ channel against the oldest prediction.
module tb;

   // A cycle limit for stretches in which neither channel moves an item.
   localparam int unsigned IDLE_LIMIT   = 1000;
   // Cycles to linger after the last expected token item has arrived.
   localparam int unsigned DRAIN_CYCLES = 8;
   // Size of the whole stimulus, in input items; the last document may run
   // a little past it.
   localparam int unsigned RANDOM_ITEMS = 900;

   // One input item as the sender holds it. When hold is set, the sender
   // waits until every predicted token item has come out before offering it.
   typedef struct packed {
      logic [7:0] ch;
      logic       eot;
      logic       hold;
   } text_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] text_byte
   logic        req_tlast = 1'b0; // end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [7:0] token_byte, [8] token_end, rest zero
   logic [3:0]  rsp_tuser;        // [2:0] token_kind, [3] byte_present
   logic        rsp_tlast;        // last_of_run

   markup_tag_tokenizer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   text_item_type       text_queue[$];       // input items not yet offered
   mtt_pkg::tok_type    expected_tokens[$];  // predicted token items, oldest first
   mtt_pkg::tok_type    step_tokens[$];      // token items of the input item being scanned
   mtt_pkg::state_type  parse_state = mtt_pkg::ST_IDLE;

   bit          hold_next    = 1'b0;
   bit          req_taken    = 1'b0;
   bit          send_steady  = 1'b0;
   bit          recv_steady  = 1'b0;
   int unsigned send_gap     = 0;
   int unsigned recv_stall   = 0;
   int unsigned idle_cycles  = 0;
   int unsigned error_count  = 0;
   int unsigned items_total  = 0;
   int unsigned items_taken  = 0;
   int unsigned tokens_seen  = 0;
   int unsigned double_items = 0;
   int unsigned documents    = 0;
   int unsigned holds        = 0;

   // ------------------------------------------------------------------
   // Token predictor
   // ------------------------------------------------------------------

   // Letters, digits and the dash may appear in names; only ASCII counts.
   function automatic bit is_name_char(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) ||   // '0' .. '9'
             (c >= 8'h41 && c <= 8'h5A) ||   // 'A' .. 'Z'
             (c >= 8'h61 && c <= 8'h7A) ||   // 'a' .. 'z'
             c == mtt_pkg::CH_DASH;
   endfunction

   function automatic void add_token(input logic [2:0] kind, input logic [7:0] ch,
                                     input logic present, input logic tend);
      mtt_pkg::tok_type tok;
      tok.kind    = kind;
      tok.tbyte   = present ? ch : 8'h00;
      tok.present = present;
      tok.tend    = tend;
      tok.last    = 1'b0;
      step_tokens = {step_tokens, tok};
   endfunction

   // Scans one accepted input item and appends its token items to the
   // expectation store. A character may be looked at again in a new state
   // (a non-space byte ends an attribute name, a '>' falls back to the
   // tag state), so the scan loops until it settles, at most four times.
   function automatic void tokenize_byte(input logic [7:0] c, input logic eot);
      bit      again;
      int      pass;
      step_tokens.delete();
      if (eot || c == mtt_pkg::CH_NUL) begin
         // End of text, or a zero byte, closes whatever token is open.
         case (parse_state)
            mtt_pkg::ST_TEXT:  add_token(mtt_pkg::KIND_TEXT, 8'h00, 1'b0, 1'b1);
            mtt_pkg::ST_TNAME: add_token(mtt_pkg::KIND_TNAME, 8'h00, 1'b0, 1'b1);
            mtt_pkg::ST_ANAME: add_token(mtt_pkg::KIND_ANAME, 8'h00, 1'b0, 1'b1);
            mtt_pkg::ST_VALUE: add_token(mtt_pkg::KIND_VALUE, 8'h00, 1'b0, 1'b1);
            default: ;
         endcase
         parse_state = mtt_pkg::ST_IDLE;
      end else begin
         again = 1'b1;
         for (pass = 0; pass < 4 && again; pass++) begin
            again = 1'b0;
            case (parse_state)
               mtt_pkg::ST_IDLE: begin
                  if (c == mtt_pkg::CH_LT) begin
                     add_token(mtt_pkg::KIND_OPEN, c, 1'b1, 1'b1);
                     parse_state = mtt_pkg::ST_TAG;
                  end else begin
                     add_token(mtt_pkg::KIND_TEXT, c, 1'b1, 1'b0);
                     parse_state = mtt_pkg::ST_TEXT;
                  end
               end
               mtt_pkg::ST_TEXT: begin
                  if (c == mtt_pkg::CH_LT) begin
                     add_token(mtt_pkg::KIND_TEXT, 8'h00, 1'b0, 1'b1);
                     add_token(mtt_pkg::KIND_OPEN, c, 1'b1, 1'b1);
                     parse_state = mtt_pkg::ST_TAG;
                  end else begin
                     add_token(mtt_pkg::KIND_TEXT, c, 1'b1, 1'b0);
                  end
               end
               mtt_pkg::ST_TAG: begin
                  if (c == mtt_pkg::CH_GT) begin
                     add_token(mtt_pkg::KIND_CLOSE, c, 1'b1, 1'b1);
                     parse_state = mtt_pkg::ST_IDLE;
                  end else if (c == mtt_pkg::CH_SLASH) begin
                     add_token(mtt_pkg::KIND_SLASH, c, 1'b1, 1'b1);
                  end else if (c == mtt_pkg::CH_SPACE) begin
                     parse_state = mtt_pkg::ST_TSPACE;
                  end else begin
                     add_token(mtt_pkg::KIND_TNAME, c, 1'b1, 1'b0);
                     parse_state = mtt_pkg::ST_TNAME;
                  end
               end
               mtt_pkg::ST_TNAME: begin
                  if (c == mtt_pkg::CH_GT) begin
                     add_token(mtt_pkg::KIND_TNAME, 8'h00, 1'b0, 1'b1);
                     add_token(mtt_pkg::KIND_CLOSE, c, 1'b1, 1'b1);
                     parse_state = mtt_pkg::ST_IDLE;
                  end else if (c == mtt_pkg::CH_SPACE) begin
                     add_token(mtt_pkg::KIND_TNAME, 8'h00, 1'b0, 1'b1);
                     parse_state = mtt_pkg::ST_TSPACE;
                  end else if (c == mtt_pkg::CH_SLASH) begin
                     add_token(mtt_pkg::KIND_TNAME, 8'h00, 1'b0, 1'b1);
                     add_token(mtt_pkg::KIND_SLASH, c, 1'b1, 1'b1);
                     parse_state = mtt_pkg::ST_TAG;
                  end else begin
                     add_token(mtt_pkg::KIND_TNAME, c, 1'b1, 1'b0);
                  end
               end
               mtt_pkg::ST_TSPACE: begin
                  if (c == mtt_pkg::CH_GT) begin
                     add_token(mtt_pkg::KIND_CLOSE, c, 1'b1, 1'b1);
                     parse_state = mtt_pkg::ST_IDLE;
                  end else if (c != mtt_pkg::CH_SPACE) begin
                     parse_state = mtt_pkg::ST_ASTART;
                     again = 1'b1;
                  end
               end
               mtt_pkg::ST_ASTART: begin
                  // Spaces and stray characters are dropped here.
                  if (c == mtt_pkg::CH_SPACE) begin
                  end else if (is_name_char(c)) begin
                     add_token(mtt_pkg::KIND_ANAME, c, 1'b1, 1'b0);
                     parse_state = mtt_pkg::ST_ANAME;
                  end else if (c == mtt_pkg::CH_EQ) begin
                     add_token(mtt_pkg::KIND_EQ, c, 1'b1, 1'b1);
                     parse_state = mtt_pkg::ST_VSTART;
                  end else if (c == mtt_pkg::CH_SLASH || c == mtt_pkg::CH_GT) begin
                     parse_state = mtt_pkg::ST_TAG;
                     again = 1'b1;
                  end
               end
               mtt_pkg::ST_ANAME: begin
                  if (is_name_char(c)) begin
                     add_token(mtt_pkg::KIND_ANAME, c, 1'b1, 1'b0);
                  end else begin
                     add_token(mtt_pkg::KIND_ANAME, 8'h00, 1'b0, 1'b1);
                     parse_state = mtt_pkg::ST_ASTART;
                     again = (c != mtt_pkg::CH_SPACE);
                  end
               end
               mtt_pkg::ST_VSTART: begin
                  // Anything but a quote or a space is looked at again as at attribute start,
                  // so an unquoted value reads as an attribute name.
                  if (c == mtt_pkg::CH_QUOTE) begin
                     parse_state = mtt_pkg::ST_VALUE;
                  end else if (c != mtt_pkg::CH_SPACE) begin
                     parse_state = mtt_pkg::ST_ASTART;
                     again = 1'b1;
                  end
               end
               mtt_pkg::ST_VALUE: begin
                  if (c == mtt_pkg::CH_QUOTE) begin
                     add_token(mtt_pkg::KIND_VALUE, 8'h00, 1'b0, 1'b1);
                     parse_state = mtt_pkg::ST_ASTART;
                  end else begin
                     add_token(mtt_pkg::KIND_VALUE, c, 1'b1, 1'b0);
                  end
               end
               default: begin
                  parse_state = mtt_pkg::ST_IDLE;
                  again = 1'b1;
               end
            endcase
         end
      end
      if (step_tokens.size() > 0)
         step_tokens[step_tokens.size() - 1].last = 1'b1;
      if (step_tokens.size() > 1)
         double_items++;
      expected_tokens = {expected_tokens, step_tokens};
   endfunction

   // ------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------

   task automatic push_item(input logic [7:0] ch, input logic eot);
      text_item_type it;
      it.ch   = ch;
      it.eot  = eot;
      it.hold = hold_next;
      hold_next = 1'b0;
      if (eot || ch == mtt_pkg::CH_NUL)
         documents++;
      text_queue = {text_queue, it};
   endtask

   function automatic logic [7:0] name_char();
      int unsigned r;
      r = $urandom_range(0, 62);
      if (r < 10)
         return 8'(8'h30 + r);         // digit
      else if (r < 36)
         return 8'(8'h41 + r - 10);    // upper-case letter
      else if (r < 62)
         return 8'(8'h61 + r - 36);    // lower-case letter
      return mtt_pkg::CH_DASH;
   endfunction

   // Any non-zero byte but '<', so a run of text stays text.
   function automatic logic [7:0] text_char();
      logic [7:0] c;
      c = 8'($urandom_range(1, 255));
      return (c == mtt_pkg::CH_LT) ? 8'hFF : c;
   endfunction

   // Any non-zero byte but the quote, for the inside of a quoted value.
   function automatic logic [7:0] value_char();
      logic [7:0] c;
      c = 8'($urandom_range(1, 255));
      return (c == mtt_pkg::CH_QUOTE) ? 8'h80 : c;
   endfunction

   task automatic push_name(input int unsigned len);
      repeat (len) push_item(name_char(), 1'b0);
   endtask

   task automatic push_quoted_value();
      push_item(mtt_pkg::CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 5)) push_item(value_char(), 1'b0);
      push_item(mtt_pkg::CH_QUOTE, 1'b0);
   endtask

   // A tag, mostly well formed, with a few attributes of every shape and
   // now and then a stray character or a missing '>'.
   task automatic push_tag();
      int unsigned attrs;
      push_item(mtt_pkg::CH_LT, 1'b0);
      if ($urandom_range(0, 3) == 0)
         push_item(mtt_pkg::CH_SLASH, 1'b0);
      push_name($urandom_range(1, 6));
      attrs = $urandom_range(0, 3);
      repeat (attrs) begin
         repeat ($urandom_range(1, 2)) push_item(mtt_pkg::CH_SPACE, 1'b0);
         push_name($urandom_range(1, 5));
         case ($urandom_range(0, 5))
            0: ;
            1, 2: begin
               push_item(mtt_pkg::CH_EQ, 1'b0);
               push_quoted_value();
            end
            3: begin
               push_item(mtt_pkg::CH_EQ, 1'b0);
               push_name($urandom_range(1, 3));
            end
            4: begin
               push_item(mtt_pkg::CH_SPACE, 1'b0);
               push_item(mtt_pkg::CH_EQ, 1'b0);
               push_item(mtt_pkg::CH_SPACE, 1'b0);
               push_quoted_value();
            end
            default: begin
               push_item(mtt_pkg::CH_SPACE, 1'b0);
               push_item(8'($urandom_range(33, 126)), 1'b0);
            end
         endcase
      end
      if ($urandom_range(0, 2) == 0)
         push_item(mtt_pkg::CH_SPACE, 1'b0);
      if ($urandom_range(0, 3) == 0)
         push_item(mtt_pkg::CH_SLASH, 1'b0);
      if ($urandom_range(0, 7) != 0)
         push_item(mtt_pkg::CH_GT, 1'b0);
   endtask

   // End of a document, either by the end flag with a random byte beside
   // it or by a zero byte.
   task automatic push_end();
      if ($urandom_range(0, 2) == 0)
         push_item(mtt_pkg::CH_NUL, 1'b0);
      else
         push_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // ------------------------------------------------------------------
   // Sender: offers one item at a time, with a random gap before each one.
   // ------------------------------------------------------------------

   function automatic int unsigned draw_wait(input bit steady);
      return steady ? 0 : $urandom_range(0, 9);
   endfunction

   always @(negedge clock) begin
      text_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (text_queue.size() > 0 &&
                      !(text_queue[0].hold && expected_tokens.size() != 0)) begin
            it = text_queue.pop_front();
            if (it.hold)
               holds++;
            req_tdata  <= it.ch;
            req_tlast  <= it.eot;
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 39) == 0)
               send_steady = !send_steady;
            send_gap = draw_wait(send_steady);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // ------------------------------------------------------------------
   // Receiver: after each token item it stalls for a random number of cycles.
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: predicts on input handshakes, checks on output handshakes,
   // and watches for a stuck block.
   // ------------------------------------------------------------------

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      mtt_pkg::tok_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tokenize_byte(req_tdata, req_tlast);
            req_taken = 1'b1;
            items_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            tokens_seen++;
            if (expected_tokens.size() == 0) begin
               error_count++;
               $display("%0t: unexpected token item, expected none, actual kind %0d tdata 0x%0h",
                        $time, rsp_tuser[2:0], rsp_tdata);
            end else begin
               want = expected_tokens.pop_front();
               compare_field("token_kind", 32'(want.kind), 32'(rsp_tuser[2:0]));
               compare_field("byte_present", 32'(want.present), 32'(rsp_tuser[3]));
               compare_field("token_byte", 32'(want.tbyte), 32'(rsp_tdata[7:0]));
               compare_field("token_end", 32'(want.tend), 32'(rsp_tdata[8]));
               compare_field("tdata padding", 0, 32'(rsp_tdata[15:9]));
               compare_field("last_of_run", 32'(want.last), 32'(rsp_tlast));
            end
            if ($urandom_range(0, 39) == 0)
               recv_steady = !recv_steady;
            recv_stall = draw_wait(recv_steady);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d token items outstanding",
                     $time, IDLE_LIMIT, expected_tokens.size());
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------

   initial begin
      // Hand-written opening: a tag name ended by a slash, a stray character
      // among attributes, an attribute name ended by '=', an empty quoted
      // value, an unquoted value, a close right after an attribute name,
      // bytes with the top bit set, end of text inside a tag name with a
      // byte beside the flag, an unclosed value ended by a zero byte, and
      // end of text inside plain text.
      push_item(mtt_pkg::CH_LT, 1'b0);
      push_item(8'h74, 1'b0);        // 't'
      push_item(mtt_pkg::CH_SLASH, 1'b0);
      push_item(mtt_pkg::CH_SPACE, 1'b0);
      push_item(8'h23, 1'b0);        // '#', dropped
      push_item(8'h6B, 1'b0);        // 'k'
      push_item(mtt_pkg::CH_EQ, 1'b0);
      push_item(mtt_pkg::CH_QUOTE, 1'b0);
      push_item(mtt_pkg::CH_QUOTE, 1'b0);
      push_item(8'h76, 1'b0);        // 'v'
      push_item(mtt_pkg::CH_EQ, 1'b0);
      push_item(8'h77, 1'b0);        // 'w'
      push_item(mtt_pkg::CH_GT, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item(8'h80, 1'b0);
      push_item(mtt_pkg::CH_LT, 1'b0);
      push_item(8'h71, 1'b0);        // 'q'
      push_item(8'hFF, 1'b1);
      push_item(mtt_pkg::CH_LT, 1'b0);
      push_item(mtt_pkg::CH_SPACE, 1'b0);
      push_item(8'h61, 1'b0);        // 'a'
      push_item(mtt_pkg::CH_EQ, 1'b0);
      push_item(mtt_pkg::CH_QUOTE, 1'b0);
      push_item(8'h7A, 1'b0);        // 'z'
      push_item(mtt_pkg::CH_NUL, 1'b0);
      push_item(8'h01, 1'b0);
      push_item(8'h00, 1'b1);

      // Random documents: mostly text and tags, with some raw noise, ends
      // of text at arbitrary points, and now and then a pause of the sender
      // until the block has delivered everything.
      hold_next = 1'b1;
      while (text_queue.size() < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
               repeat ($urandom_range(0, 6)) push_item(text_char(), 1'b0);
               push_tag();
            end
            12, 13:
               repeat ($urandom_range(1, 6))
                  push_item(8'($urandom_range(0, 255)), 1'b0);
            14, 15, 16:
               push_end();
            17:
               hold_next = 1'b1;
            default:
               push_tag();
         endcase
      end
      push_end();
      items_total = text_queue.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (items_taken < items_total)
         @(negedge clock);
      while (expected_tokens.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run covered %0d input items in %0d documents, %0d token items checked.",
               items_taken, documents, tokens_seen);
      $display("Input items with two token items: %0d; sender drain pauses: %0d.",
               double_items, holds);
      if (error_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
